### design/tgi_pkg.sv
// ----------------------------------------------------------------------------
// tgi_pkg
// shared types and constants of the trilinear grid interpolator
// ----------------------------------------------------------------------------
package tgi_pkg;

  localparam int ADDR_W      = 12;
  localparam int STORE_DEPTH = 4096;
  localparam int SAMPLE_W    = 16;
  localparam int COORD_W     = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CORNER_W    = 3;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_INV_STEP_X = 3'd3,
    CFG_INV_STEP_Y = 3'd4,
    CFG_INV_STEP_Z = 3'd5
  } cfg_reg_t;

  // operand select of the shared lerp unit
  typedef enum logic [1:0] {
    LSEL_X  = 2'd0,
    LSEL_Y0 = 2'd1,
    LSEL_Y1 = 2'd2,
    LSEL_Z  = 2'd3
  } lerp_sel_t;

  typedef struct packed {
    logic                       kind;
    logic [ADDR_W-1:0]          grid_address;
    logic signed [SAMPLE_W-1:0] grid_value;
    logic signed [COORD_W-1:0]  query_x;
    logic signed [COORD_W-1:0]  query_y;
    logic signed [COORD_W-1:0]  query_z;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] interpolated;
    logic                       out_of_range;
  } out_item_t;

  // controller to datapath commands
  typedef struct packed {
    logic                write_grid;
    logic                load_query;
    logic                calc_prod;
    logic                calc_split;
    logic                calc_base;
    logic                rd_en;
    logic [CORNER_W-1:0] corner;
    lerp_sel_t           lerp_sel;
    logic                emit;
  } cmd_t;

endpackage

### design/tgi_ctrl.sv
// ----------------------------------------------------------------------------
// tgi_ctrl
// sequencer: axis math, eight corner reads, y and z lerps
// ----------------------------------------------------------------------------
module tgi_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_kind,
  output logic          busy,
  output tgi_pkg::cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_MUL     = 9'b000000010,
    S_SPLIT   = 9'b000000100,
    S_ADDR    = 9'b000001000,
    S_FETCH   = 9'b000010000,
    S_DRAIN   = 9'b000100000,
    S_LERP_Y0 = 9'b001000000,
    S_LERP_Y1 = 9'b010000000,
    S_LERP_Z  = 9'b100000000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [tgi_pkg::CORNER_W-1:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.lerp_sel = tgi_pkg::LSEL_X;
    cmd.corner   = cnt_r;
    busy         = 1'b1;
    case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (in_kind == tgi_pkg::KIND_QUERY) begin
            cmd.load_query = 1'b1;
            state_nxt      = S_MUL;
          end else begin
            cmd.write_grid = 1'b1;
          end
        end
      end
      S_MUL: begin
        cmd.calc_prod = 1'b1;
        state_nxt     = S_SPLIT;
      end
      S_SPLIT: begin
        cmd.calc_split = 1'b1;
        state_nxt      = S_ADDR;
      end
      S_ADDR: begin
        cmd.calc_base = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_FETCH;
      end
      S_FETCH: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_LERP_Y0;
      end
      S_LERP_Y0: begin
        cmd.lerp_sel = tgi_pkg::LSEL_Y0;
        state_nxt    = S_LERP_Y1;
      end
      S_LERP_Y1: begin
        cmd.lerp_sel = tgi_pkg::LSEL_Y1;
        state_nxt    = S_LERP_Z;
      end
      S_LERP_Z: begin
        cmd.lerp_sel = tgi_pkg::LSEL_Z;
        cmd.emit     = 1'b1;
        state_nxt    = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### design/tgi_datapath.sv
// ----------------------------------------------------------------------------
// tgi_datapath
// config registers, axis split, grid memory and shared lerp unit
// ----------------------------------------------------------------------------
module tgi_datapath #(
  parameter int GRID_NX   = 16,
  parameter int GRID_NY   = 16,
  parameter int GRID_NZ   = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tgi_pkg::cmd_t                    cmd,
  input  tgi_pkg::in_item_t                in_item,
  input  logic                             cfg_we,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tgi_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                             out_valid,
  output tgi_pkg::out_item_t               out_item
);

  localparam int ADDR_W = tgi_pkg::ADDR_W;
  localparam int SW     = tgi_pkg::SAMPLE_W;
  localparam int PROD_W = 34;                  // 17b signed diff x 17b step
  localparam int POS_W  = PROD_W + 8;          // room for up to 16 fraction bits
  localparam int SHL    = (FRAC_BITS >= 8) ? FRAC_BITS - 8 : 0;
  localparam int SHR    = (FRAC_BITS >= 8) ? 0 : 8 - FRAC_BITS;
  localparam int FW     = FRAC_BITS + 1;       // fraction includes the full value
  localparam int N_XY   = (GRID_NX > GRID_NY) ? GRID_NX : GRID_NY;
  localparam int N_MAX  = (N_XY > GRID_NZ) ? N_XY : GRID_NZ;
  localparam int CELL_W = $clog2(N_MAX);
  localparam int LP_W   = SW + 1 + FW + 1;

  localparam logic [ADDR_W-1:0] STRIDE_X =
    ADDR_W'((GRID_NY * GRID_NZ) % tgi_pkg::STORE_DEPTH);
  localparam logic [ADDR_W-1:0] STRIDE_Y = ADDR_W'(GRID_NZ % tgi_pkg::STORE_DEPTH);
  localparam logic [FW-1:0]     FULL     = FW'(1) << FRAC_BITS;
  localparam logic signed [LP_W-1:0] HALF = LP_W'(1) << (FRAC_BITS - 1);

  // grid size along one axis
  function automatic int axis_n(input int a);
    case (a)
      0:       return GRID_NX;
      1:       return GRID_NY;
      default: return GRID_NZ;
    endcase
  endfunction

  // configuration registers
  logic signed [15:0] origin_r   [3];
  logic        [15:0] inv_step_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        origin_r[a]   <= '0;
        inv_step_r[a] <= 16'd256;
      end
    end else if (cfg_we) begin
      case (cfg_index)
        tgi_pkg::CFG_ORIGIN_X:   origin_r[0]   <= $signed(cfg_data);
        tgi_pkg::CFG_ORIGIN_Y:   origin_r[1]   <= $signed(cfg_data);
        tgi_pkg::CFG_ORIGIN_Z:   origin_r[2]   <= $signed(cfg_data);
        tgi_pkg::CFG_INV_STEP_X: inv_step_r[0] <= cfg_data;
        tgi_pkg::CFG_INV_STEP_Y: inv_step_r[1] <= cfg_data;
        tgi_pkg::CFG_INV_STEP_Z: inv_step_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // query point and axis products
  logic signed [15:0]       query_r [3];
  logic signed [16:0]       diff    [3];
  logic signed [PROD_W-1:0] prod_r  [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a] = {query_r[a][15], query_r[a]} - {origin_r[a][15], origin_r[a]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      query_r[0] <= in_item.query_x;
      query_r[1] <= in_item.query_y;
      query_r[2] <= in_item.query_z;
    end
    if (cmd.calc_prod) begin
      for (int a = 0; a < 3; a++) begin
        prod_r[a] <= diff[a] * $signed({1'b0, inv_step_r[a]});
      end
    end
  end

  // split each position into cell and fraction, clamp at the grid edges
  logic signed [POS_W-1:0] pos      [3];
  logic signed [POS_W-1:0] top      [3];
  logic [CELL_W-1:0]       cell_nxt [3];
  logic [FW-1:0]           frac_nxt [3];
  logic [2:0]              clamp;
  logic [CELL_W-1:0]       cell_r   [3];
  logic [FW-1:0]           frac_r   [3];
  logic                    oor_r;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      pos[a] = POS_W'(prod_r[a]);
      pos[a] = (pos[a] <<< SHL) >>> SHR;
      top[a] = $signed(POS_W'(axis_n(a) - 1) << FRAC_BITS);
      if (pos[a][POS_W-1]) begin
        // below the grid: first cell, zero fraction
        cell_nxt[a] = '0;
        frac_nxt[a] = '0;
        clamp[a]    = 1'b1;
      end else if (pos[a] >= top[a]) begin
        // at or past the last plane: last cell, full fraction
        cell_nxt[a] = CELL_W'(axis_n(a) - 2);
        frac_nxt[a] = FULL;
        clamp[a]    = (pos[a] > top[a]);
      end else begin
        cell_nxt[a] = pos[a][FRAC_BITS +: CELL_W];
        frac_nxt[a] = {1'b0, pos[a][FRAC_BITS-1:0]};
        clamp[a]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_split) begin
      cell_r <= cell_nxt;
      frac_r <= frac_nxt;
      oor_r  <= |clamp;
    end
  end

  // corner addressing, wrapped to the store depth
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] rd_addr;

  always_ff @(posedge clk) begin
    if (cmd.calc_base) begin
      base_r <= ADDR_W'(cell_r[0]) * STRIDE_X + ADDR_W'(cell_r[1]) * STRIDE_Y
              + ADDR_W'(cell_r[2]);
    end
  end

  always_comb begin
    rd_addr = base_r + (cmd.corner[0] ? STRIDE_X : '0)
                     + (cmd.corner[1] ? STRIDE_Y : '0)
                     + ADDR_W'(cmd.corner[2]);
  end

  // grid memory, single port
  logic [SW-1:0]                grid_mem [tgi_pkg::STORE_DEPTH];
  logic signed [SW-1:0]         rdata_r;
  logic                         rd_valid_r;
  logic [tgi_pkg::CORNER_W-1:0] rd_corner_r;

  always_ff @(posedge clk) begin
    if (cmd.write_grid) begin
      grid_mem[in_item.grid_address] <= in_item.grid_value;
    end
    if (cmd.rd_en) begin
      rdata_r <= $signed(grid_mem[rd_addr]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r  <= 1'b0;
      rd_corner_r <= '0;
    end else begin
      rd_valid_r  <= cmd.rd_en;
      rd_corner_r <= cmd.corner;
    end
  end

  // shared lerp unit: a + floor(((b - a) * f + half) / 2^frac)
  logic signed [SW-1:0]   a_r;
  logic signed [SW-1:0]   s_r [4];
  logic signed [SW-1:0]   t_r [2];
  logic signed [SW-1:0]   lp_a, lp_b, lp_res;
  logic [FW-1:0]          lp_f;
  logic signed [SW:0]     lp_diff;
  logic signed [LP_W-1:0] lp_prod, lp_sum;

  always_comb begin
    lp_a = a_r;
    lp_b = rdata_r;
    lp_f = frac_r[0];
    case (cmd.lerp_sel)
      tgi_pkg::LSEL_Y0: begin
        lp_a = s_r[0];
        lp_b = s_r[1];
        lp_f = frac_r[1];
      end
      tgi_pkg::LSEL_Y1: begin
        lp_a = s_r[2];
        lp_b = s_r[3];
        lp_f = frac_r[1];
      end
      tgi_pkg::LSEL_Z: begin
        lp_a = t_r[0];
        lp_b = t_r[1];
        lp_f = frac_r[2];
      end
      default: ;
    endcase
    lp_diff = {lp_b[SW-1], lp_b} - {lp_a[SW-1], lp_a};
    lp_prod = lp_diff * $signed({1'b0, lp_f});
    lp_sum  = lp_prod + HALF;
    // result lies between a and b, so it fits the sample width
    lp_res  = SW'(LP_W'(lp_a) + (lp_sum >>> FRAC_BITS));
  end

  always_ff @(posedge clk) begin
    if (rd_valid_r) begin
      if (rd_corner_r[0]) begin
        s_r[rd_corner_r[2:1]] <= lp_res;
      end else begin
        a_r <= rdata_r;
      end
    end
    if (cmd.lerp_sel == tgi_pkg::LSEL_Y0) begin
      t_r[0] <= lp_res;
    end
    if (cmd.lerp_sel == tgi_pkg::LSEL_Y1) begin
      t_r[1] <= lp_res;
    end
    if (cmd.emit) begin
      out_item.interpolated <= lp_res;
      out_item.out_of_range <= oor_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.emit;
    end
  end

endmodule

### design/trilinear_grid_interpolator_unit.sv
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator_unit
// trilinear interpolation over an evenly spaced 3d grid held in on-chip ram
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A load request
// (kind 0) writes one sample into the 4096-entry grid ram in that same
// cycle and leaves busy low, so loads can stream one per cycle. A query
// request (kind 1) holds busy high through the per-axis scale, split and
// base address steps, eight corner reads through the single-ported grid
// ram, a drain step for the last read to land and the y and z lerps; the
// x lerps run alongside the reads. The result shows on out_item for
// exactly one cycle with out_valid high, in the first cycle busy is low
// again. The receiver cannot stall the block, so out_valid must be sampled
// on every cycle. The grid ram is not cleared at reset; every corner a
// query touches must be loaded first. Configuration writes through
// cfg_we/cfg_index/cfg_data take effect at once and are only allowed
// while no query is in flight.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator_unit #(
  parameter int GRID_NX   = 16,
  parameter int GRID_NY   = 16,
  parameter int GRID_NZ   = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // request channel
  input  logic                           start,
  output logic                           busy,
  input  tgi_pkg::in_item_t              in_item,
  // result channel, one-cycle strobe
  output logic                           out_valid,
  output tgi_pkg::out_item_t             out_item,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [tgi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tgi_pkg::CFG_DATA_W-1:0] cfg_data
);

  // command bundle from sequencer to datapath
  tgi_pkg::cmd_t cmd;

  // sequencer: owns busy and the corner counter
  tgi_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_item.kind),
    .busy    (busy),
    .cmd     (cmd)
  );

  // datapath: config registers, grid ram, axis split and lerp unit
  tgi_datapath #(
    .GRID_NX   (GRID_NX),
    .GRID_NY   (GRID_NY),
    .GRID_NZ   (GRID_NZ),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

### design/tgi_checker.sv
// ----------------------------------------------------------------------------
// tgi_checker
// port-level checks of request and result timing
// ----------------------------------------------------------------------------
module tgi_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input tgi_pkg::in_item_t in_item,
  input logic              out_valid
);

  // a query request occupies the block
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == tgi_pkg::KIND_QUERY) |=> busy)
    else $error("query request did not raise busy");

  // a load request finishes in its own cycle
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.kind == tgi_pkg::KIND_WRITE) |=> !busy)
    else $error("load request raised busy");

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // a result only follows the busy phase of a query
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result outside the end of a query");

endmodule

bind trilinear_grid_interpolator_unit tgi_checker u_tgi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid)
);

### tb/trilinear_grid_interpolator_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_grid_interpolator_checker
// Mirrors the grid ram and the frame registers from the observed load and
// config traffic. It predicts the interpolated value and the clamp flag of
// every accepted query, and checks each result strobe against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module trilinear_grid_interpolator_checker
  import tgi_pkg::*;
#(
  parameter int GRID_NX   = 16,
  parameter int GRID_NY   = 16,
  parameter int GRID_NZ   = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_valid,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatch_count,
  output int                    pending_count
);

  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;
  localparam int STEP_FRAC = 8;  // inv_step is Q8.8
  localparam logic [CFG_DATA_W-1:0] INV_STEP_RESET = 16'd256;
  localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAMPLE_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
  localparam int MAX_REPORTS = 10;

  logic signed [SAMPLE_W-1:0] grid_mirror [STORE_DEPTH];
  logic signed [COORD_W-1:0]  origin_r [3];
  logic [CFG_DATA_W-1:0]      inv_step_r [3];
  out_item_t                  expected_q [$];

  // grid position of one coordinate, split into cell and fraction
  function automatic void split_axis(input logic signed [COORD_W-1:0] coord,
                                     input int axis, input int n,
                                     output longint cell_idx, output longint frac,
                                     output logic clamped);
    longint full_frac, prod, pos, top_pos;
    full_frac = longint'(1) <<< FRAC_BITS;
    prod = (longint'(coord) - longint'(origin_r[axis])) * longint'(inv_step_r[axis]);
    pos = (prod * full_frac) >>> STEP_FRAC;
    top_pos = longint'(n - 1) * full_frac;
    clamped = 1'b0;
    if (pos < 0) begin
      cell_idx = 0;
      frac     = 0;
      clamped  = 1'b1;
    end else if (pos >= top_pos) begin
      cell_idx = n - 2;
      frac     = full_frac;
      clamped  = (pos > top_pos);
    end else begin
      cell_idx = pos >>> FRAC_BITS;
      frac     = pos - cell_idx * full_frac;
    end
  endfunction

  function automatic longint corner_sample(input longint ix, input longint iy,
                                           input longint iz);
    longint flat;
    flat = (ix * GRID_NY + iy) * GRID_NZ + iz;
    return longint'(grid_mirror[flat & (STORE_DEPTH - 1)]);
  endfunction

  // a + (b - a) * f, rounded half up
  function automatic longint lerp_step(input longint a, input longint b, input longint f);
    return a + (((b - a) * f + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
  endfunction

  function automatic out_item_t predict_interpolation(input in_item_t req);
    longint cx, cy, cz, fx, fy, fz;
    longint s0, s1, s2, s3, t0, t1, r;
    logic ox, oy, oz;
    out_item_t res;
    split_axis(req.query_x, AXIS_X, GRID_NX, cx, fx, ox);
    split_axis(req.query_y, AXIS_Y, GRID_NY, cy, fy, oy);
    split_axis(req.query_z, AXIS_Z, GRID_NZ, cz, fz, oz);
    s0 = lerp_step(corner_sample(cx, cy, cz), corner_sample(cx + 1, cy, cz), fx);
    s1 = lerp_step(corner_sample(cx, cy + 1, cz), corner_sample(cx + 1, cy + 1, cz), fx);
    s2 = lerp_step(corner_sample(cx, cy, cz + 1), corner_sample(cx + 1, cy, cz + 1), fx);
    s3 = lerp_step(corner_sample(cx, cy + 1, cz + 1),
                   corner_sample(cx + 1, cy + 1, cz + 1), fx);
    t0 = lerp_step(s0, s1, fy);
    t1 = lerp_step(s2, s3, fy);
    r  = lerp_step(t0, t1, fz);
    if (r > SAMPLE_MAX) r = SAMPLE_MAX;
    if (r < SAMPLE_MIN) r = SAMPLE_MIN;
    res.interpolated = r[SAMPLE_W-1:0];
    res.out_of_range = ox | oy | oz;
    return res;
  endfunction

  task automatic note_mismatch(input string what, input out_item_t want,
                               input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("%0t ns: %s: expected value %0d oor %0b, got value %0d oor %0b",
               $time, what, want.interpolated, want.out_of_range,
               got.interpolated, got.out_of_range);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      origin_r[AXIS_X]   = '0;
      origin_r[AXIS_Y]   = '0;
      origin_r[AXIS_Z]   = '0;
      inv_step_r[AXIS_X] = INV_STEP_RESET;
      inv_step_r[AXIS_Y] = INV_STEP_RESET;
      inv_step_r[AXIS_Z] = INV_STEP_RESET;
      expected_q.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ORIGIN_X:   origin_r[AXIS_X]   = cfg_data;
          CFG_ORIGIN_Y:   origin_r[AXIS_Y]   = cfg_data;
          CFG_ORIGIN_Z:   origin_r[AXIS_Z]   = cfg_data;
          CFG_INV_STEP_X: inv_step_r[AXIS_X] = cfg_data;
          CFG_INV_STEP_Y: inv_step_r[AXIS_Y] = cfg_data;
          CFG_INV_STEP_Z: inv_step_r[AXIS_Z] = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_item.kind == KIND_WRITE)
          grid_mirror[in_item.grid_address] = in_item.grid_value;
        else
          expected_q.push_back(predict_interpolation(in_item));
      end
      if (out_valid) begin
        if (expected_q.size() == 0) begin
          note_mismatch("result with no query pending", '0, out_item);
        end else begin
          want = expected_q.pop_front();
          if (out_item.interpolated !== want.interpolated ||
              out_item.out_of_range !== want.out_of_range)
            note_mismatch("result differs", want, out_item);
        end
      end
    end
    pending_count = expected_q.size();
  end

endmodule

### tb/tb_trilinear_grid_interpolator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trilinear_grid_interpolator_unit
// Loads the grid entries around cells 0, 7 and 14 of every axis, runs
// directed queries on the grid edges, the clamp cases and full-scale corner
// values, then random load and query traffic under several frame settings
// (extreme origins and step reciprocals, zero step included), with varying
// request gaps. Every query selects only loaded cells. A separate checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_trilinear_grid_interpolator_unit;
  import tgi_pkg::*;

  localparam int GRID_NX   = 16;
  localparam int GRID_NY   = 16;
  localparam int GRID_NZ   = 16;
  localparam int FRAC_BITS = 8;

  localparam int HALF_PERIOD      = 2;
  localparam int RESET_CYCLES     = 11;
  localparam int SETTLE_CYCLES    = 24;      // query latency plus margin
  localparam int CYCLE_LIMIT      = 400000;
  localparam int INV_ONE          = 256;     // 1.0 in Q8.8
  localparam int STEP_FRAC        = 8;       // inv_step is Q8.8
  localparam int RANDOM_PER_PHASE = 52;
  localparam int CELL_STRIDE      = 7;       // queries only select multiples of this
  localparam int AXIS_X = 0;
  localparam int AXIS_Y = 1;
  localparam int AXIS_Z = 2;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  start     = 1'b0;
  logic                  busy;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  out_item_t             out_item;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  int mismatch_count;
  int pending_count;
  int cycle_count = 0;
  int idle_pct    = 0;   // chance in percent of holding a request back a cycle
  int random_sent = 0;
  int origin_now [3];    // current frame, only used to aim queries at the grid
  int inv_now    [3];

  always #(HALF_PERIOD) clk = ~clk;

  trilinear_grid_interpolator_unit #(
    .GRID_NX  (GRID_NX),
    .GRID_NY  (GRID_NY),
    .GRID_NZ  (GRID_NZ),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  trilinear_grid_interpolator_checker #(
    .GRID_NX  (GRID_NX),
    .GRID_NY  (GRID_NY),
    .GRID_NZ  (GRID_NZ),
    .FRAC_BITS(FRAC_BITS)
  ) result_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_item       (in_item),
    .out_valid     (out_valid),
    .out_item      (out_item),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatch_count(mismatch_count),
    .pending_count (pending_count)
  );

  // watchdog: a hung handshake or a lost result ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // sample values lean toward full scale so the lerps see the extremes
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int roll;
    roll = $urandom_range(0, 7);
    if (roll == 0) return 16'sh8000;
    if (roll == 1) return 16'sh7fff;
    return SAMPLE_W'($urandom);
  endfunction

  // load request, query fields are don't-care noise
  function automatic in_item_t make_load(input int addr, input int value);
    in_item_t req;
    req.kind         = KIND_WRITE;
    req.grid_address = ADDR_W'(addr);
    req.grid_value   = SAMPLE_W'(value);
    req.query_x      = COORD_W'($urandom);
    req.query_y      = COORD_W'($urandom);
    req.query_z      = COORD_W'($urandom);
    return req;
  endfunction

  // query request, load fields are don't-care noise
  function automatic in_item_t make_query(input int x, input int y, input int z);
    in_item_t req;
    req.kind         = KIND_QUERY;
    req.grid_address = ADDR_W'($urandom);
    req.grid_value   = SAMPLE_W'($urandom);
    req.query_x      = COORD_W'(x);
    req.query_y      = COORD_W'(y);
    req.query_z      = COORD_W'(z);
    return req;
  endfunction

  function automatic int corner_addr(input int ix, input int iy, input int iz);
    return (ix * GRID_NY + iy) * GRID_NZ + iz;
  endfunction

  // cell a coordinate selects on one axis, clamped the way the block clamps
  function automatic int axis_cell(input int axis, input int n, input int coord);
    longint pos, top_pos;
    pos = (longint'($signed(COORD_W'(coord))) - longint'(origin_now[axis]))
          * longint'(inv_now[axis]);
    pos = (pos <<< FRAC_BITS) >>> STEP_FRAC;
    top_pos = longint'(n - 1) <<< FRAC_BITS;
    if (pos < 0) return 0;
    if (pos >= top_pos) return n - 2;
    return int'(pos >>> FRAC_BITS);
  endfunction

  // coordinate landing inside the grid or just past either edge; a zero
  // step maps everything to position 0, so any value will do there
  function automatic int aim_coord(input int axis, input int n);
    int t, q;
    do begin
      if (inv_now[axis] == 0) begin
        q = int'($urandom);
      end else begin
        t = int'($urandom_range(0, (n - 1) * INV_ONE + 64)) - 32;
        q = origin_now[axis] + t / inv_now[axis];
      end
    end while (axis_cell(axis, n, q) % CELL_STRIDE != 0);
    return q;
  endfunction

  // fully random coordinate, kept only if it selects a loaded cell
  function automatic int rand_coord(input int axis, input int n);
    int q;
    do begin
      q = int'($urandom);
    end while (axis_cell(axis, n, q) % CELL_STRIDE != 0);
    return q;
  endfunction

  // one request: optional hold-off, then hold start until the block takes it
  // (busy is stable at the falling edge, so it tells whether the next rising
  // edge accepts)
  task automatic send(input in_item_t req);
    logic taken;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do begin
      taken = !busy;
      @(negedge clk);
    end while (!taken);
  endtask

  // drop start, let every pending query come back, then a latency's worth
  // of quiet cycles
  task automatic settle();
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // cfg_we stays high across back-to-back writes, the caller lowers it
  task automatic write_reg(input cfg_reg_t idx, input int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(negedge clk);
  endtask

  // new grid frame, written only while the block is idle
  task automatic program_frame(input int ox, input int oy, input int oz,
                               input int sx, input int sy, input int sz);
    settle();
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_INV_STEP_X, sx);
    write_reg(CFG_INV_STEP_Y, sy);
    write_reg(CFG_INV_STEP_Z, sz);
    cfg_we <= 1'b0;
    origin_now = '{int'($signed(COORD_W'(ox))), int'($signed(COORD_W'(oy))),
                   int'($signed(COORD_W'(oz)))};
    inv_now    = '{sx, sy, sz};
  endtask

  // random traffic: ~30% loads, the rest queries, of which a quarter carry
  // fully random coordinates and the others are aimed at the grid
  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // gap regime: light idling, then heavy idling, then none
      if (random_sent < 2 * RANDOM_PER_PHASE)
        idle_pct = 22;
      else if (random_sent < 4 * RANDOM_PER_PHASE)
        idle_pct = 87;
      else
        idle_pct = 0;
      if ($urandom_range(0, 9) < 3)
        send(make_load($urandom_range(0, STORE_DEPTH - 1), pick_sample()));
      else if ($urandom_range(0, 3) == 0)
        send(make_query(rand_coord(AXIS_X, GRID_NX), rand_coord(AXIS_Y, GRID_NY),
                        rand_coord(AXIS_Z, GRID_NZ)));
      else
        send(make_query(aim_coord(AXIS_X, GRID_NX), aim_coord(AXIS_Y, GRID_NY),
                        aim_coord(AXIS_Z, GRID_NZ)));
      random_sent++;
    end
  endtask

  initial begin
    origin_now = '{0, 0, 0};
    inv_now    = '{INV_ONE, INV_ONE, INV_ONE};
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners of every cell a query may select get written first
    idle_pct = 22;
    for (int ix = 0; ix < GRID_NX; ix++)
      for (int iy = 0; iy < GRID_NY; iy++)
        for (int iz = 0; iz < GRID_NZ; iz++)
          if (ix % CELL_STRIDE <= 1 && iy % CELL_STRIDE <= 1 && iz % CELL_STRIDE <= 1)
            send(make_load(corner_addr(ix, iy, iz), pick_sample()));

    // reset frame: one grid step per coordinate unit
    send(make_query(0, 0, 0));                                // first corner
    send(make_query(GRID_NX - 1, GRID_NY - 1, GRID_NZ - 1));  // exactly on top edge
    send(make_query(GRID_NX, 7, 0));                          // one step beyond x
    send(make_query(7, -1, 14));                              // below y
    send(make_query(14, 0, GRID_NZ));                         // beyond z
    send(make_query(-32768, 32767, 7));                       // coordinate extremes
    send(make_query(32767, -32768, -32768));
    send(make_load(0, -32768));                               // address and value extremes
    send(make_load(STORE_DEPTH - 1, 32767));
    send(make_query(0, 0, 0));
    send(make_query(GRID_NX - 1, GRID_NY - 1, GRID_NZ - 1));

    // half-step frame: full-scale corners of opposite sign, midpoint query
    program_frame(0, 0, 0, INV_ONE / 2, INV_ONE / 2, INV_ONE / 2);
    for (int c = 0; c < 8; c++)
      send(make_load(corner_addr(7 + c[2], 7 + c[1], 7 + c[0]),
                     (^c[2:0]) ? 32767 : -32768));
    send(make_query(15, 15, 15));
    run_random(RANDOM_PER_PHASE);

    // uneven spacing per axis
    program_frame(-100, 50, 3, 300, 77, 1000);
    run_random(RANDOM_PER_PHASE);

    // extreme origins, finest and coarsest step, zero step on z
    program_frame(-32768, 32767, 12345, 1, 65535, 0);
    run_random(RANDOM_PER_PHASE);

    // random frame
    program_frame(int'($urandom_range(0, 4000)) - 2000, int'($urandom_range(0, 4000)) - 2000,
                  int'($urandom_range(0, 4000)) - 2000, $urandom_range(16, 2048),
                  $urandom_range(16, 2048), $urandom_range(16, 2048));
    run_random(RANDOM_PER_PHASE);

    // opposite extremes
    program_frame(32767, -32768, 0, 65535, 1, INV_ONE);
    run_random(RANDOM_PER_PHASE);

    // back to the reset frame, written explicitly
    program_frame(0, 0, 0, INV_ONE, INV_ONE, INV_ONE);
    run_random(RANDOM_PER_PHASE);

    // drain and verdict
    settle();
    if (mismatch_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
